### rtl/core/kway_pair_merge_defines.svh
// ----------------------------------------------------------------------------
// kway_pair_merge_defines
// Assertion macros for the k-way pair merge block.
// ----------------------------------------------------------------------------
`ifndef KWAY_PAIR_MERGE_DEFINES_SVH
`define KWAY_PAIR_MERGE_DEFINES_SVH

// Checked at every edge outside reset.
`define KPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KPM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/kpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_pkg
// Shared types and constants of the k-way pair merge block.
// ----------------------------------------------------------------------------
package kpm_pkg;

	localparam int unsigned MAX_RUNS_DEF = 64;
	localparam int unsigned RUN_W        = 8;   // holds any run index up to 255
	localparam int unsigned LIM_W        = 9;   // holds a run count up to 256
	localparam int unsigned DATA_W       = 64;
	localparam logic [6:0]  RUNS_RESET   = 7'd64;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_REFILL = 2'd2;
	localparam logic [1:0] KIND_SPARE  = 2'd3;   // unused kind, ignored

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PEND
	} state_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic              found;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		logic [RUN_W-1:0]  run;
	} tok_t;

	// head write broadcast to all cells
	typedef struct packed {
		logic              en;
		logic              present;
		logic [RUN_W-1:0]  run;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} wr_t;

	// head clear broadcast after an emit
	typedef struct packed {
		logic             en;
		logic [RUN_W-1:0] run;
	} clr_t;

	function automatic logic pair_before(input logic [DATA_W-1:0] ka,
		input logic [DATA_W-1:0] va, input logic [DATA_W-1:0] kb,
		input logic [DATA_W-1:0] vb);
		return (ka < kb) || ((ka == kb) && (va < vb));
	endfunction

endpackage

### rtl/core/kway_pair_merge.sv
`timescale 1ns / 1ps
// Timing: a load beat is written into its head cell on acceptance. A start or refill
//   beat is registered in launch_q; the search token then walks the MAX_RUNS head
//   cells one cell per cycle, and the result waits in the pending registers until the
//   output register is free. No new beat is taken until then; loads go back to back.
// Reset: arst_n clears all head valid bits, the emit count, the last run,
//   and sets runs_in_use to 64. Head data is not cleared.
// ----------------------------------------------------------------------------
// kway_pair_merge
// K-way merge of sorted key/value runs over a chain of head cells.
// ----------------------------------------------------------------------------
module kway_pair_merge #(
	parameter int unsigned MAX_RUNS = kpm_pkg::MAX_RUNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: runs_in_use
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata,
	// input beats
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [5:0]  run_index,
	input  logic        present,
	input  logic [63:0] pair_key,
	input  logic [63:0] pair_value,
	// result beats
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_key,
	output logic [63:0] out_value,
	output logic [5:0]  out_run,
	output logic [63:0] emitted_total,
	output logic        done_res
);

	`include "kway_pair_merge_defines.svh"

	kpm_pkg::state_t              state_q, state_d;
	logic [6:0]                   runs_q;
	logic [kpm_pkg::LIM_W-1:0]    lim;
	logic [5:0]                   last_run_q;
	logic [63:0]                  count_q;
	logic                         launch_q;
	logic                         in_acc;
	logic                         emit_acc;
	logic                         move;
	logic                         tail_vld;
	kpm_pkg::wr_t                 wr;
	kpm_pkg::clr_t                clr;
	kpm_pkg::tok_t                chain [MAX_RUNS+1];
	logic [MAX_RUNS-1:0]          tokv;

	// pending result, held until the output register is free
	logic        pend_done_q;
	logic [63:0] pend_key_q, pend_value_q, pend_total_q;
	logic [5:0]  pend_run_q;

	assign in_acc   = in_valid && !in_stall;
	assign emit_acc = in_acc &&
		((kind == kpm_pkg::KIND_START) || (kind == kpm_pkg::KIND_REFILL));
	assign tail_vld = chain[MAX_RUNS].vld;
	assign move     = (state_q == kpm_pkg::ST_PEND) && (!out_valid || !out_stall);

	// effective run count: min(runs_in_use, MAX_RUNS)
	assign lim = (kpm_pkg::LIM_W'(runs_q) < kpm_pkg::LIM_W'(MAX_RUNS)) ?
		kpm_pkg::LIM_W'(runs_q) : kpm_pkg::LIM_W'(MAX_RUNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_q <= kpm_pkg::RUNS_RESET;
		end else if (cfg_wen) begin
			runs_q <= cfg_wdata;
		end
	end

	// head writes: a load targets run_index, a refill the run emitted last
	always_comb begin
		wr.en      = in_acc && ((kind == kpm_pkg::KIND_LOAD) || (kind == kpm_pkg::KIND_REFILL));
		wr.present = present;
		wr.run     = (kind == kpm_pkg::KIND_LOAD) ? kpm_pkg::RUN_W'(run_index) :
			kpm_pkg::RUN_W'(last_run_q);
		wr.key     = pair_key;
		wr.value   = pair_value;
	end

	// drop the emitted head when the token leaves the chain with a winner
	always_comb begin
		clr.en  = tail_vld && chain[MAX_RUNS].found;
		clr.run = chain[MAX_RUNS].run;
	end

	// launch the token in the cycle after acceptance so a refill write is visible
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
		end else begin
			launch_q <= emit_acc;
		end
	end

	always_comb begin
		chain[0]       = '0;
		chain[0].vld   = launch_q;
	end

	for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
		kpm_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lim    (lim),
			.wr     (wr),
			.clr    (clr),
			.tok_i  (chain[i]),
			.tok_o  (chain[i+1])
		);
		assign tokv[i] = chain[i].vld;
	end

	// commit the emit as the token leaves the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_run_q <= '0;
			count_q    <= '0;
		end else if (clr.en) begin
			last_run_q <= chain[MAX_RUNS].run[5:0];
			count_q    <= count_q + 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_vld) begin
			pend_done_q <= !chain[MAX_RUNS].found;
			if (chain[MAX_RUNS].found) begin
				pend_key_q   <= chain[MAX_RUNS].key;
				pend_value_q <= chain[MAX_RUNS].value;
				pend_run_q   <= chain[MAX_RUNS].run[5:0];
				pend_total_q <= count_q + 64'd1;
			end else begin
				pend_key_q   <= '0;
				pend_value_q <= '0;
				pend_run_q   <= '0;
				pend_total_q <= count_q;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kpm_pkg::ST_IDLE: if (emit_acc) state_d = kpm_pkg::ST_SCAN;
			kpm_pkg::ST_SCAN: if (tail_vld) state_d = kpm_pkg::ST_PEND;
			kpm_pkg::ST_PEND: if (move)     state_d = kpm_pkg::ST_IDLE;
			default:                        state_d = kpm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// outputs of the state machine: hold input while a search runs or its result is pending
	always_comb begin
		case (state_q)
			kpm_pkg::ST_IDLE: in_stall = 1'b0;
			default:          in_stall = 1'b1;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (move) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_key       <= pend_key_q;
			out_value     <= pend_value_q;
			out_run       <= pend_run_q;
			emitted_total <= pend_total_q;
			done_res      <= pend_done_q;
		end
	end

	`KPM_ASSERT(a_one_token, $onehot0(tokv), "more than one search token in the chain")
	`KPM_ASSERT(a_tail_in_scan, tail_vld |-> (state_q == kpm_pkg::ST_SCAN),
		"token left chain outside scan")
	`KPM_ASSERT(a_out_from_pend, $rose(out_valid) |-> ($past(state_q) == kpm_pkg::ST_PEND),
		"result without pending beat")

endmodule

### rtl/core/kpm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_cell
// One run head plus one compare stage of the search chain.
// ----------------------------------------------------------------------------
module kpm_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [kpm_pkg::LIM_W-1:0] lim,
	input  kpm_pkg::wr_t             wr,
	input  kpm_pkg::clr_t            clr,
	input  kpm_pkg::tok_t            tok_i,
	output kpm_pkg::tok_t            tok_o
);

	logic                         valid_q;
	logic [kpm_pkg::DATA_W-1:0]   key_q;
	logic [kpm_pkg::DATA_W-1:0]   value_q;
	kpm_pkg::tok_t                tok_q;
	logic                         active;
	logic                         take;

	assign active = (kpm_pkg::LIM_W'(IDX) < lim);
	assign take   = valid_q && active &&
		(!tok_i.found || kpm_pkg::pair_before(key_q, value_q, tok_i.key, tok_i.value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && (wr.run == kpm_pkg::RUN_W'(IDX)) && active) begin
			valid_q <= wr.present;
		end else if (clr.en && (clr.run == kpm_pkg::RUN_W'(IDX))) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.present && (wr.run == kpm_pkg::RUN_W'(IDX)) && active) begin
			key_q   <= wr.key;
			value_q <= wr.value;
		end
	end

	// advance the token, replacing the best so far where this head wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld <= tok_i.vld;
			if (take) begin
				tok_q.found <= 1'b1;
				tok_q.key   <= key_q;
				tok_q.value <= value_q;
				tok_q.run   <= kpm_pkg::RUN_W'(IDX);
			end else begin
				tok_q.found <= tok_i.found;
				tok_q.key   <= tok_i.key;
				tok_q.value <= tok_i.value;
				tok_q.run   <= tok_i.run;
			end
		end
	end

	assign tok_o = tok_q;

endmodule

### tb/sv/kpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_checker
// Watches both channels of the merge block, keeps its own copy of the run
// heads and predicts every emitted pair, then compares each result beat.
// ----------------------------------------------------------------------------
module kpm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [5:0]  run_index,
	input  logic        present,
	input  logic [63:0] pair_key,
	input  logic [63:0] pair_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] out_key,
	input  logic [63:0] out_value,
	input  logic [5:0]  out_run,
	input  logic [63:0] emitted_total,
	input  logic        done_res,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [63:0] key;
		logic [63:0] value;
		logic [5:0]  run;
		logic [63:0] total;
		logic        done;
	} emit_t;

	emit_t       emit_queue[$];
	logic [63:0] head_key[64];
	logic [63:0] head_val[64];
	bit          head_live[64];
	logic [5:0]  last_run;
	logic [63:0] emit_count;
	logic [6:0]  runs_used;

	function automatic int unsigned live_runs();
		return (runs_used < 64) ? runs_used : 64;
	endfunction

	task automatic write_head(input int unsigned run, input logic pres,
		input logic [63:0] k, input logic [63:0] v);
		if (run < live_runs()) begin
			head_live[run] = pres;
			if (pres) begin
				head_key[run] = k;
				head_val[run] = v;
			end
		end
	endtask

	task automatic predict_emit();
		emit_t e;
		int    best;
		best = -1;
		for (int i = 0; i < live_runs(); i++) begin
			if (head_live[i] && (best < 0 || head_key[i] < head_key[best] ||
					(head_key[i] == head_key[best] && head_val[i] < head_val[best])))
				best = i;
		end
		if (best < 0) begin
			e = '{key: '0, value: '0, run: '0, total: emit_count, done: 1'b1};
		end else begin
			head_live[best] = 0;
			last_run = best[5:0];
			emit_count++;
			e = '{key: head_key[best], value: head_val[best], run: best[5:0],
				total: emit_count, done: 1'b0};
		end
		emit_queue.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		emit_t e;
		if (!arst_n) begin
			foreach (head_live[i]) head_live[i] = 0;
			last_run = '0;
			emit_count = '0;
			runs_used = kpm_pkg::RUNS_RESET;
			emit_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_wen)
				runs_used = cfg_wdata;
			if (in_valid && !in_stall) begin
				case (kind)
				kpm_pkg::KIND_LOAD: write_head(run_index, present, pair_key, pair_value);
				kpm_pkg::KIND_START: predict_emit();
				kpm_pkg::KIND_REFILL: begin
					write_head(last_run, present, pair_key, pair_value);
					predict_emit();
				end
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (emit_queue.size() == 0) begin
					$display("%0t: unexpected result key %h run %0d done %0b",
						$time, out_key, out_run, done_res);
					fail_count++;
				end else begin
					e = emit_queue.pop_front();
					if (out_key !== e.key || out_value !== e.value || out_run !== e.run ||
							emitted_total !== e.total || done_res !== e.done) begin
						$display("%0t: mismatch expected key %h value %h run %0d total %0d done %0b",
							$time, e.key, e.value, e.run, e.total, e.done);
						$display("%0t:          actual   key %h value %h run %0d total %0d done %0b",
							$time, out_key, out_value, out_run, emitted_total, done_res);
						fail_count++;
					end
				end
			end
		end
		pending = emit_queue.size();
	end
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Merge block stimulus: directed corner beats, then phases of merges (heads
// loaded, start, refills mixed with stray beats) under varying run counts, with
// random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb;

	localparam int LAT = kpm_pkg::MAX_RUNS_DEF + 8;   // drain margin after last result

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [6:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [5:0]  run_index;
	logic        present;
	logic [63:0] pair_key;
	logic [63:0] pair_value;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] out_key;
	logic [63:0] out_value;
	logic [5:0]  out_run;
	logic [63:0] emitted_total;
	logic        done_res;
	int          fail_count;
	int          pending;

	int in_idle_pct  = 21;   // chance in a hundred of a gap before a beat
	int out_idle_pct = 21;   // chance in a hundred of a stall cycle
	int hold_req     = 0;    // cycles of forced result hold-off requested
	int hold_left    = 0;
	int beats_sent   = 0;

	kway_pair_merge uut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .run_index(run_index),
		.present(present), .pair_key(pair_key), .pair_value(pair_value),
		.out_valid(out_valid), .out_stall(out_stall), .out_key(out_key),
		.out_value(out_value), .out_run(out_run), .emitted_total(emitted_total),
		.done_res(done_res)
	);

	kpm_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .run_index(run_index),
		.present(present), .pair_key(pair_key), .pair_value(pair_value),
		.out_valid(out_valid), .out_stall(out_stall), .out_key(out_key),
		.out_value(out_value), .out_run(out_run), .emitted_total(emitted_total),
		.done_res(done_res), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Result side: random stalls, plus a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	// Mix of small keys (forces ties), extremes and full-width random.
	function automatic logic [63:0] pick_word();
		case ($urandom_range(3))
		0: return 64'($urandom_range(7));
		1: return $urandom_range(1) ? '1 : '0;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offer one beat and hold it until accepted.
	task automatic send_beat(input logic [1:0] k, input logic [5:0] run,
		input logic pres, input logic [63:0] key, input logic [63:0] value);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		run_index  <= run;
		present    <= pres;
		pair_key   <= key;
		pair_value <= value;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	// Drop valid, drain all results, then let any load still in flight settle.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic set_runs(input logic [6:0] n);
		settle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// One merge: load heads, start, then refill the run just emitted.
	task automatic merge_phase(input int nrun, input int nref);
		int top_run;
		top_run = (nrun > 64) ? 64 : nrun;
		for (int r = 0; r < top_run; r++)
			send_beat(kpm_pkg::KIND_LOAD, r[5:0], $urandom_range(99) < 80,
				pick_word(), pick_word());
		send_beat(kpm_pkg::KIND_START, 6'($urandom), 1'($urandom), pick_word(), pick_word());
		for (int i = 0; i < nref; i++) begin
			case ($urandom_range(19))
			0: send_beat(kpm_pkg::KIND_SPARE, 6'($urandom), 1'($urandom),
				pick_word(), pick_word());
			1: send_beat(kpm_pkg::KIND_LOAD, 6'($urandom), 1'($urandom),
				pick_word(), pick_word());
			2: send_beat(kpm_pkg::KIND_START, 6'($urandom), 1'($urandom),
				pick_word(), pick_word());
			default: send_beat(kpm_pkg::KIND_REFILL, 6'($urandom), $urandom_range(99) < 85,
				pick_word(), pick_word());
			endcase
		end
	endtask

	initial begin
		int n;
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		kind       = kpm_pkg::KIND_LOAD;
		run_index  = '0;
		present    = 1'b0;
		pair_key   = '0;
		pair_value = '0;
		out_stall  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: refill before any emit goes to run 0, extremes, ties, kind three.
		send_beat(kpm_pkg::KIND_REFILL, 6'd0, 1'b1, 64'd5, 64'd5);
		send_beat(kpm_pkg::KIND_LOAD, 6'd63, 1'b1, '0, '1);
		send_beat(kpm_pkg::KIND_LOAD, 6'd62, 1'b1, '0, '0);
		send_beat(kpm_pkg::KIND_LOAD, 6'd2, 1'b1, 64'd9, 64'd1);
		send_beat(kpm_pkg::KIND_LOAD, 6'd3, 1'b1, 64'd9, 64'd1);
		send_beat(kpm_pkg::KIND_LOAD, 6'd4, 1'b1, '1, '1);
		send_beat(kpm_pkg::KIND_LOAD, 6'd5, 1'b0, '1, '0);
		send_beat(kpm_pkg::KIND_SPARE, 6'd1, 1'b1, '0, '0);
		send_beat(kpm_pkg::KIND_START, '1, 1'b1, '1, '1);
		send_beat(kpm_pkg::KIND_START, '0, 1'b0, '0, '0);
		send_beat(kpm_pkg::KIND_REFILL, '0, 1'b1, 64'd9, 64'd1);
		send_beat(kpm_pkg::KIND_REFILL, '0, 1'b0, '0, '0);
		repeat (8) send_beat(kpm_pkg::KIND_START, '0, 1'b0, '0, '0);

		// One run: loads above it dropped, refill keeps run 0 going.
		set_runs(7'd1);
		send_beat(kpm_pkg::KIND_LOAD, 6'd1, 1'b1, '0, '0);
		send_beat(kpm_pkg::KIND_LOAD, 6'd0, 1'b1, '1, '0);
		send_beat(kpm_pkg::KIND_START, '0, 1'b0, '0, '0);
		send_beat(kpm_pkg::KIND_REFILL, '0, 1'b1, '0, '1);
		send_beat(kpm_pkg::KIND_START, '0, 1'b0, '0, '0);
		// No run in use: every emit is done.
		set_runs(7'd0);
		send_beat(kpm_pkg::KIND_LOAD, 6'd0, 1'b1, '0, '0);
		send_beat(kpm_pkg::KIND_START, '0, 1'b0, '0, '0);
		send_beat(kpm_pkg::KIND_REFILL, '0, 1'b1, '0, '0);

		// Full count beyond MAX_RUNS, with a long no-idle stretch.
		set_runs(7'd127);
		in_idle_pct  = 0;
		out_idle_pct = 0;
		merge_phase(64, 20);
		in_idle_pct  = 21;
		out_idle_pct = 21;

		// Hold results off while the sender keeps offering refills.
		set_runs(7'd4);
		hold_req = 400;
		merge_phase(4, 20);

		while (beats_sent < 450) begin
			case ($urandom_range(9))
			0: n = 64 + $urandom_range(63);
			1: n = $urandom_range(1, 64);
			default: n = $urandom_range(1, 8);
			endcase
			set_runs(n[6:0]);
			merge_phase(n > 16 ? 16 : n, $urandom_range(4, 24));
		end

		settle();
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end
endmodule
